// File: sv/srt_pkg.sv
package srt_pkg;

	localparam logic [1:0] FUNC_RECT  = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_SKIP  = 2'd3;

	localparam int CB = 12;

	localparam logic [1:0] REG_WARMUP = 2'd0;
	localparam logic [1:0] REG_PURGE  = 2'd1;
	localparam logic [1:0] REG_MINM   = 2'd2;
	localparam logic [1:0] REG_MAXM   = 2'd3;

	localparam logic [10:0] FC_MAX    = 11'd2047;
	localparam logic [15:0] MATCH_MAX = 16'hFFFF;
	localparam logic [4:0]  MISS_MAX  = 5'd31;

	typedef struct packed {
		logic [1:0]    func;
		logic [CB-1:0] rect_x;
		logic [CB-1:0] rect_y;
		logic [CB-1:0] rect_width;
		logic [CB-1:0] rect_height;
		logic          last_in_frame;
	} in_word_t;

	typedef struct packed {
		logic [CB-1:0] out_x;
		logic [CB-1:0] out_y;
		logic [CB-1:0] out_width;
		logic [CB-1:0] out_height;
		logic          has_rect;
		logic          list_unchanged;
		logic          last_of_list;
	} out_word_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] w;
		logic [CB-1:0] h;
	} box_t;

	typedef struct packed {
		box_t        box;
		logic [10:0] birth;
		logic [15:0] match_cnt;
		logic [4:0]  misses;
	} entry_t;

endpackage

// File: sv/static_rect_tracker.sv
// Input: a rectangle word without frame end is taken while idle, and the input stays open for the next word.
// A frame end keeps the input closed while the single match unit walks the entry and rectangle
// memories and the results are sent, and for longer while the result port stalls.
// Throughput: one word at a time; the next word is taken once the frame's last result is loaded.
// Reset: table and buffer empty, frame counter zero, registers at 1000, 1000, 20, 15.
module static_rect_tracker
	import srt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int FRAME_RECTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TW = $clog2(TABLE_DEPTH + 1);
	localparam int TI = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(FRAME_RECTS + 1);
	localparam int FI = (FRAME_RECTS > 1) ? $clog2(FRAME_RECTS) : 1;
	localparam logic [5:0] MAX_OUT = 6'd32;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PRG_RD = 4'd1;
	localparam logic [3:0] ST_PRG_WR = 4'd2;
	localparam logic [3:0] ST_ENT_RD = 4'd3;
	localparam logic [3:0] ST_RCT_RD = 4'd4;
	localparam logic [3:0] ST_CMP = 4'd5;
	localparam logic [3:0] ST_CMP2 = 4'd6;
	localparam logic [3:0] ST_CMP3 = 4'd7;
	localparam logic [3:0] ST_ENT_WR = 4'd8;
	localparam logic [3:0] ST_APP_RD = 4'd9;
	localparam logic [3:0] ST_APP_WR = 4'd10;
	localparam logic [3:0] ST_EMT_RD = 4'd11;
	localparam logic [3:0] ST_EMT = 4'd12;
	localparam logic [3:0] ST_OUT = 4'd13;
	localparam logic [3:0] ST_FIN = 4'd14;

	logic [3:0]  state_q;
	logic [10:0] warm_q, purge_q, fc_q;
	logic [7:0]  minm_q;
	logic [4:0]  maxm_q;
	logic [TW-1:0] ecnt_q, rd_q, wr_q;
	logic [FW-1:0] fcnt_q, ri_q;
	logic [FRAME_RECTS-1:0] taken_q;
	logic        purge_mode_q, hit_q, empty_q;
	logic [5:0]  nout_q;

	entry_t ent_mem [TABLE_DEPTH];
	box_t   rct_mem [FRAME_RECTS];
	entry_t ent_rd_q, ent_cur_q;
	box_t   rct_rd_q;
	logic        ent_we, rct_we;
	logic [TI-1:0] ent_wa, ent_ra;
	logic [FI-1:0] rct_wa, rct_ra;
	entry_t ent_wd;
	box_t   rct_wd;
	logic   hit_s2;
	logic   in_acc, out_acc;
	logic   cfg_wr;
	out_word_t out_q;
	logic   ov_q;
	logic   out_load;
	box_t   hold_q;
	logic   hold_v_q;
	logic   stable;
	entry_t upd;

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_wa] <= ent_wd;
		ent_rd_q <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (rct_we)
			rct_mem[rct_wa] <= rct_wd;
		rct_rd_q <= rct_mem[rct_ra];
	end

	srt_match u_match (
		.clk    (clk),
		.a      (ent_cur_q.box),
		.b      (rct_rd_q),
		.hit_s2 (hit_s2)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (paddr[3:2])
			REG_WARMUP: prdata = {21'd0, warm_q};
			REG_PURGE:  prdata = {21'd0, purge_q};
			REG_MINM:   prdata = {24'd0, minm_q};
			REG_MAXM:   prdata = {27'd0, maxm_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = ov_q;
	assign out_data = out_q;
	assign out_acc = ov_q && out_ready;
	assign out_load = ((state_q == ST_OUT) || (state_q == ST_FIN)) && (!ov_q || out_acc);

	assign ent_ra = rd_q[TI-1:0];
	assign rct_ra = ri_q[FI-1:0];
	assign stable = (ent_rd_q.match_cnt > {8'd0, minm_q}) && (ent_rd_q.birth > warm_q);

	always_comb begin
		upd = ent_cur_q;
		if (hit_q) begin
			upd.box = rct_rd_q;
			if (ent_cur_q.match_cnt != MATCH_MAX)
				upd.match_cnt = ent_cur_q.match_cnt + 16'd1;
			upd.misses = 5'd0;
		end else if (ent_cur_q.misses != MISS_MAX) begin
			upd.misses = ent_cur_q.misses + 5'd1;
		end
	end

	always_comb begin
		ent_we = 1'b0;
		ent_wa = wr_q[TI-1:0];
		ent_wd = ent_cur_q;
		rct_we = 1'b0;
		rct_wa = fcnt_q[FI-1:0];
		rct_wd = '{x: in_data.rect_x, y: in_data.rect_y,
			w: in_data.rect_width, h: in_data.rect_height};
		case (state_q)
			ST_IDLE: rct_we = in_acc && (in_data.func == FUNC_RECT) &&
				(fcnt_q < FW'(FRAME_RECTS));
			ST_PRG_WR: ent_we = (ent_rd_q.birth > warm_q);
			ST_PRG_RD: ent_wd = ent_rd_q;
			ST_ENT_WR: begin
				ent_we = hit_q || (upd.misses <= maxm_q);
				ent_wd = upd;
			end
			ST_APP_WR: begin
				ent_we = !taken_q[ri_q[FI-1:0]] && (wr_q < TW'(TABLE_DEPTH));
				ent_wd = '{box: rct_rd_q, birth: fc_q, match_cnt: 16'd0, misses: 5'd0};
			end
			default: ;
		endcase
		if (state_q == ST_PRG_WR)
			ent_wd = ent_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			warm_q <= 11'd1000;
			purge_q <= 11'd1000;
			minm_q <= 8'd20;
			maxm_q <= 5'd15;
			fc_q <= 11'd0;
			ecnt_q <= '0;
			fcnt_q <= '0;
			taken_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			ri_q <= '0;
			hit_q <= 1'b0;
			empty_q <= 1'b0;
			purge_mode_q <= 1'b0;
			nout_q <= '0;
			ov_q <= 1'b0;
			out_q <= '0;
			ent_cur_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WARMUP: warm_q <= pwdata[10:0];
					REG_PURGE:  purge_q <= pwdata[10:0];
					REG_MINM:   minm_q <= pwdata[7:0];
					REG_MAXM:   maxm_q <= pwdata[4:0];
					default: ;
				endcase
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (out_acc)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					if (in_data.func == FUNC_CLEAR) begin
						ecnt_q <= '0;
						fcnt_q <= '0;
						taken_q <= '0;
						fc_q <= 11'd0;
					end else if (in_data.func == FUNC_RECT ||
						in_data.func == FUNC_FRAME) begin
						if (rct_we)
							fcnt_q <= fcnt_q + 1'b1;
						if (in_data.func == FUNC_FRAME || in_data.last_in_frame) begin
							rd_q <= '0;
							wr_q <= '0;
							ri_q <= '0;
							nout_q <= '0;
							hold_v_q <= 1'b0;
							if (fc_q < purge_q) begin
								fc_q <= fc_q + 11'd1;
								state_q <= ST_ENT_RD;
							end else if (fc_q == purge_q && fc_q != FC_MAX) begin
								fc_q <= fc_q + 11'd1;
								state_q <= ST_PRG_RD;
							end else begin
								state_q <= ST_ENT_RD;
							end
							empty_q <= 1'b0;
						end
					end
				end
				ST_PRG_RD: begin
					if (rd_q == ecnt_q) begin
						ecnt_q <= wr_q;
						rd_q <= '0;
						wr_q <= '0;
						state_q <= ST_ENT_RD;
					end else begin
						state_q <= ST_PRG_WR;
					end
				end
				ST_PRG_WR: begin
					if (ent_we)
						wr_q <= wr_q + 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= ST_PRG_RD;
				end
				ST_ENT_RD: begin
					if (rd_q == '0 && ecnt_q == '0)
						empty_q <= 1'b1;
					if (rd_q == ecnt_q) begin
						ecnt_q <= wr_q;
						ri_q <= '0;
						state_q <= ST_APP_RD;
					end else begin
						ri_q <= '0;
						hit_q <= 1'b0;
						state_q <= ST_RCT_RD;
					end
				end
				ST_RCT_RD: begin
					ent_cur_q <= ent_rd_q;
					if (ri_q == fcnt_q)
						state_q <= ST_ENT_WR;
					else if (taken_q[ri_q[FI-1:0]])
						ri_q <= ri_q + 1'b1;
					else
						state_q <= ST_CMP;
				end
				ST_CMP: state_q <= ST_CMP2;
				ST_CMP2: state_q <= ST_CMP3;
				ST_CMP3: begin
					if (hit_s2) begin
						hit_q <= 1'b1;
						taken_q[ri_q[FI-1:0]] <= 1'b1;
						state_q <= ST_ENT_WR;
					end else begin
						ri_q <= ri_q + 1'b1;
						state_q <= ST_RCT_RD;
					end
				end
				ST_ENT_WR: begin
					if (ent_we)
						wr_q <= wr_q + 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= ST_ENT_RD;
				end
				ST_APP_RD: begin
					if (ri_q == fcnt_q) begin
						ecnt_q <= wr_q;
						fcnt_q <= '0;
						taken_q <= '0;
						rd_q <= '0;
						state_q <= empty_q ? ST_FIN : ST_EMT_RD;
					end else begin
						state_q <= ST_APP_WR;
					end
				end
				ST_APP_WR: begin
					if (ent_we)
						wr_q <= wr_q + 1'b1;
					ri_q <= ri_q + 1'b1;
					state_q <= ST_APP_RD;
				end
				ST_EMT_RD: begin
					if (rd_q == ecnt_q || nout_q == MAX_OUT)
						state_q <= ST_FIN;
					else
						state_q <= ST_EMT;
				end
				ST_EMT: begin
					if (stable && hold_v_q) begin
						state_q <= ST_OUT;
					end else begin
						rd_q <= rd_q + 1'b1;
						if (stable) begin
							hold_q <= ent_rd_q.box;
							hold_v_q <= 1'b1;
							nout_q <= nout_q + 6'd1;
						end
						state_q <= ST_EMT_RD;
					end
				end
				ST_OUT: if (out_load) begin
					out_q <= '{out_x: hold_q.x, out_y: hold_q.y,
						out_width: hold_q.w, out_height: hold_q.h,
						has_rect: 1'b1, list_unchanged: 1'b0, last_of_list: 1'b0};
					hold_v_q <= 1'b0;
					state_q <= ST_EMT_RD;
				end
				ST_FIN: if (out_load) begin
					if (hold_v_q) begin
						out_q <= '{out_x: hold_q.x, out_y: hold_q.y,
							out_width: hold_q.w, out_height: hold_q.h,
							has_rect: 1'b1, list_unchanged: 1'b0, last_of_list: 1'b1};
					end else begin
						out_q <= '{out_x: '0, out_y: '0, out_width: '0,
							out_height: '0, has_rect: 1'b0,
							list_unchanged: empty_q, last_of_list: 1'b1};
					end
					hold_v_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/srt_match.sv
module srt_match
	import srt_pkg::*;
(
	input  logic clk,
	input  box_t a,
	input  box_t b,
	output logic hit_s2
);

	logic [CB:0] ax2, ay2, bx2, by2, ix1, ix2, iy1, iy2, ux1, ux2, uy1, uy2;
	logic [CB:0] iw_s1, ih_s1, uw_s1, uh_s1;
	logic        ok_s1;
	logic [2*CB+1:0] ia, ua;

	always_comb begin
		ax2 = {1'b0, a.x} + {1'b0, a.w};
		ay2 = {1'b0, a.y} + {1'b0, a.h};
		bx2 = {1'b0, b.x} + {1'b0, b.w};
		by2 = {1'b0, b.y} + {1'b0, b.h};
		ix1 = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
		iy1 = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
		ux1 = (a.x < b.x) ? {1'b0, a.x} : {1'b0, b.x};
		uy1 = (a.y < b.y) ? {1'b0, a.y} : {1'b0, b.y};
		ix2 = (ax2 < bx2) ? ax2 : bx2;
		iy2 = (ay2 < by2) ? ay2 : by2;
		ux2 = (ax2 > bx2) ? ax2 : bx2;
		uy2 = (ay2 > by2) ? ay2 : by2;
	end

	always_ff @(posedge clk) begin
		ok_s1 <= (ix2 > ix1) && (iy2 > iy1);
		iw_s1 <= ix2 - ix1;
		ih_s1 <= iy2 - iy1;
		uw_s1 <= ux2 - ux1;
		uh_s1 <= uy2 - uy1;
	end

	always_comb begin
		ia = iw_s1 * ih_s1;
		ua = uw_s1 * uh_s1;
	end

	logic [2*CB+1:0] ia_s2, ua_s2;
	logic            ok_s2;
	always_ff @(posedge clk) begin
		ia_s2 <= ia;
		ua_s2 <= ua;
		ok_s2 <= ok_s1;
	end

	assign hit_s2 = ok_s2 &&
		(({5'b0, ia_s2} << 4) + ({5'b0, ia_s2} << 2) >
		 ({5'b0, ua_s2} << 4) + ({5'b0, ua_s2} << 1) + {5'b0, ua_s2});

endmodule
